@@ src/mrc_pkg.sv @@
package mrc_pkg;

   localparam int ENTRIES   = 64;
   localparam int PAGE_BITS = 12;
   localparam int ADDR_BITS = 48;

   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int CNT_W  = IDX_W + 1;
   localparam int LNK_W  = IDX_W + 1;
   localparam int PN_W   = 36;
   localparam int SPAN_W = 20;
   localparam int REFS_W = 16;
   localparam int STMP_W = 32;
   localparam int NPG_W  = SPAN_W + 1;
   localparam int END_W  = ADDR_BITS + 1;

   localparam logic [LNK_W-1:0]  LNK_NULL = LNK_W'(ENTRIES);
   localparam logic [SPAN_W-1:0] SPAN_MAX = '1;
   localparam logic [REFS_W-1:0] REFS_MAX = '1;

   localparam logic [2:0] STS_HIT  = 3'd0;
   localparam logic [2:0] STS_NEW  = 3'd1;
   localparam logic [2:0] STS_NONE = 3'd2;
   localparam logic [2:0] STS_DROP = 3'd3;
   localparam logic [2:0] STS_IDLE = 3'd4;

   localparam logic FUNC_REG = 1'b0;

   typedef struct packed {
      logic        func;
      logic [47:0] address;
      logic [30:0] length;
      logic [5:0]  entry_id;
   } mrc_req_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [5:0]        result_entry;
      logic [PN_W-1:0]   first_page;
      logic [SPAN_W-1:0] page_count;
      logic [REFS_W-1:0] ref_count;
      logic              freed_valid;
      logic [PN_W-1:0]   freed_page;
      logic [SPAN_W-1:0] freed_count;
   } mrc_rsp_type;

   typedef struct packed {
      logic [PN_W-1:0]   page;
      logic [SPAN_W-1:0] span;
      logic [REFS_W-1:0] refs;
      logic [STMP_W-1:0] stamp;
   } mrc_entry_type;

endpackage

@@ src/memory_registration_cache_unit.sv @@
// A register beat works by a sequential scan of the entry memory, one entry per cycle through
// its single read port. An unregister beat reads the entry in S_UREAD and, when the entry
// joins the idle list, links it at the list head in S_ADD1 and S_ADD2. One beat is worked
// at a time; the result strobe is registered in the last step. Synchronous reset clears
// valid bits, free stack marks, stamp counter and list ends at once, and fills the free stack.
// Results are shown for one cycle and cannot be stalled by the receiver.
module memory_registration_cache_unit
   import mrc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  mrc_req_type req_data,
   output logic        rsp_valid,
   output mrc_rsp_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_DECIDE, S_UNLINK, S_POP, S_INSTALL, S_HITWR, S_UREAD, S_ADD1, S_ADD2
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PN_W-1:0]   first_ff, first_in;
   logic [END_W-PAGE_BITS-1:0] endpg_ff, endpg_in;
   logic [NPG_W-1:0]  npg_ff, npg_in;
   logic              best_vld_ff, best_vld_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic [STMP_W-1:0] best_age_ff, best_age_in;
   mrc_entry_type     wrk_ff, wrk_in;
   logic [IDX_W-1:0]  tgt_ff, tgt_in;
   logic              evict_ff, evict_in;
   logic              freed_vld_ff, freed_vld_in;
   logic [PN_W-1:0]   freed_pg_ff, freed_pg_in;
   logic [SPAN_W-1:0] freed_cnt_ff, freed_cnt_in;
   logic [ENTRIES-1:0] vld_ff, vld_in;
   logic [ENTRIES-1:0] stk_wr_ff, stk_wr_in;
   logic [CNT_W-1:0]  dep_ff, dep_in;
   logic [STMP_W-1:0] ctr_ff, ctr_in;
   logic [LNK_W-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic              lazy_ff, lazy_in;
   logic [IDX_W-1:0]  id_ff, id_in;
   logic              rsp_valid_ff, rsp_valid_in;
   mrc_rsp_type       rsp_ff, rsp_in;

   logic              ent_we;
   logic [IDX_W-1:0]  ent_wa, ent_ra;
   mrc_entry_type     ent_wd, ent_q;
   logic              nxt_we, prv_we;
   logic [IDX_W-1:0]  nxt_wa, prv_wa, lnk_ra;
   logic [LNK_W-1:0]  nxt_wd, prv_wd, nxt_q, prv_q;
   logic              stk_we;
   logic [IDX_W-1:0]  stk_wa, stk_ra;
   logic [IDX_W-1:0]  stk_wd, stk_q;

   logic [30:0]       len_eff;
   logic [END_W-1:0]  end_addr;
   logic [IDX_W-1:0]  eval_idx;
   logic [STMP_W-1:0] age;
   logic              match;
   logic [IDX_W-1:0]  top_idx;
   mrc_entry_type     upd;

   mrc_ram #(.WIDTH($bits(mrc_entry_type)), .DEPTH(ENTRIES)) u_ent (
      .clock(clock), .wr_en(ent_we), .wr_addr(ent_wa), .wr_data(ent_wd),
      .rd_addr(ent_ra), .rd_data(ent_q)
   );

   mrc_ram #(.WIDTH(LNK_W), .DEPTH(ENTRIES)) u_nxt (
      .clock(clock), .wr_en(nxt_we), .wr_addr(nxt_wa), .wr_data(nxt_wd),
      .rd_addr(lnk_ra), .rd_data(nxt_q)
   );

   mrc_ram #(.WIDTH(LNK_W), .DEPTH(ENTRIES)) u_prv (
      .clock(clock), .wr_en(prv_we), .wr_addr(prv_wa), .wr_data(prv_wd),
      .rd_addr(lnk_ra), .rd_data(prv_q)
   );

   mrc_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_stk (
      .clock(clock), .wr_en(stk_we), .wr_addr(stk_wa), .wr_data(stk_wd),
      .rd_addr(stk_ra), .rd_data(stk_q)
   );

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   assign len_eff  = (req_data.length == '0) ? 31'd1 : req_data.length;
   assign end_addr = {1'b0, req_data.address} + END_W'(len_eff) - END_W'(1);
   assign eval_idx = IDX_W'(cnt_ff - CNT_W'(1));
   assign age      = ctr_ff - ent_q.stamp;
   assign match    = vld_ff[eval_idx] && (ent_q.page == first_ff)
                     && ({1'b0, ent_q.span} >= npg_ff);
   assign top_idx  = IDX_W'(dep_ff - CNT_W'(1));

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      first_in     = first_ff;
      endpg_in     = endpg_ff;
      npg_in       = npg_ff;
      best_vld_in  = best_vld_ff;
      best_idx_in  = best_idx_ff;
      best_age_in  = best_age_ff;
      wrk_in       = wrk_ff;
      tgt_in       = tgt_ff;
      evict_in     = evict_ff;
      freed_vld_in = freed_vld_ff;
      freed_pg_in  = freed_pg_ff;
      freed_cnt_in = freed_cnt_ff;
      vld_in       = vld_ff;
      stk_wr_in    = stk_wr_ff;
      dep_in       = dep_ff;
      ctr_in       = ctr_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      lazy_in      = lazy_ff;
      id_in        = id_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ent_we = 1'b0;  ent_wa = tgt_ff;  ent_wd = wrk_ff;  ent_ra = cnt_ff[IDX_W-1:0];
      nxt_we = 1'b0;  nxt_wa = tgt_ff;  nxt_wd = LNK_NULL;
      prv_we = 1'b0;  prv_wa = tgt_ff;  prv_wd = LNK_NULL;
      lnk_ra = tgt_ff;
      stk_we = 1'b0;  stk_wa = dep_ff[IDX_W-1:0];  stk_wd = id_ff;  stk_ra = top_idx;
      upd    = ent_q;

      if (csr_valid) begin
         lazy_in = csr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_data.func == FUNC_REG) begin
                  first_in     = req_data.address[ADDR_BITS-1:PAGE_BITS];
                  endpg_in     = end_addr[END_W-1:PAGE_BITS];
                  cnt_in       = '0;
                  best_vld_in  = 1'b0;
                  freed_vld_in = 1'b0;
                  freed_pg_in  = '0;
                  freed_cnt_in = '0;
                  state_in     = S_SCAN;
               end else begin
                  id_in    = req_data.entry_id;
                  ent_ra   = req_data.entry_id;
                  state_in = S_UREAD;
               end
            end
         end
         S_SCAN: begin
            if (cnt_ff == '0) begin
               npg_in = NPG_W'(endpg_ff - {1'b0, first_ff} + 1'b1);
            end else if (match && (!best_vld_ff || age < best_age_ff)) begin
               best_vld_in = 1'b1;
               best_idx_in = eval_idx;
               best_age_in = age;
               wrk_in      = ent_q;
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(ENTRIES)) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (best_vld_ff) begin
               tgt_in   = best_idx_ff;
               evict_in = 1'b0;
               if (wrk_ff.refs == '0) begin
                  lnk_ra   = best_idx_ff;
                  state_in = S_UNLINK;
               end else begin
                  state_in = S_HITWR;
               end
            end else if (dep_ff == '0) begin
               if (tail_ff == LNK_NULL) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
                  rsp_in.status = STS_NONE;
                  state_in     = S_IDLE;
               end else begin
                  tgt_in   = tail_ff[IDX_W-1:0];
                  ent_ra   = tail_ff[IDX_W-1:0];
                  lnk_ra   = tail_ff[IDX_W-1:0];
                  evict_in = 1'b1;
                  state_in = S_UNLINK;
               end
            end else begin
               state_in = S_POP;
            end
         end
         S_UNLINK: begin
            if (prv_q != LNK_NULL) begin
               nxt_we = 1'b1;
               nxt_wa = prv_q[IDX_W-1:0];
               nxt_wd = nxt_q;
            end
            if (nxt_q != LNK_NULL) begin
               prv_we = 1'b1;
               prv_wa = nxt_q[IDX_W-1:0];
               prv_wd = prv_q;
            end
            if (head_ff == {1'b0, tgt_ff}) begin
               head_in = nxt_q;
            end
            if (tail_ff == {1'b0, tgt_ff}) begin
               tail_in = prv_q;
            end
            if (evict_ff) begin
               freed_vld_in   = 1'b1;
               freed_pg_in    = ent_q.page;
               freed_cnt_in   = ent_q.span;
               vld_in[tgt_ff] = 1'b0;
               state_in       = S_INSTALL;
            end else begin
               state_in = S_HITWR;
            end
         end
         S_POP: begin
            tgt_in   = stk_wr_ff[top_idx] ? stk_q : (IDX_W'(ENTRIES - 1) - top_idx);
            dep_in   = dep_ff - CNT_W'(1);
            state_in = S_INSTALL;
         end
         S_INSTALL: begin
            upd.page  = first_ff;
            upd.span  = (npg_ff > NPG_W'(SPAN_MAX)) ? SPAN_MAX : npg_ff[SPAN_W-1:0];
            upd.refs  = REFS_W'(1);
            upd.stamp = ctr_ff;
            ent_we         = 1'b1;
            ent_wa         = tgt_ff;
            ent_wd         = upd;
            vld_in[tgt_ff] = 1'b1;
            ctr_in         = ctr_ff + STMP_W'(1);
            rsp_valid_in   = 1'b1;
            rsp_in.status       = STS_NEW;
            rsp_in.result_entry = tgt_ff;
            rsp_in.first_page   = upd.page;
            rsp_in.page_count   = upd.span;
            rsp_in.ref_count    = upd.refs;
            rsp_in.freed_valid  = freed_vld_ff;
            rsp_in.freed_page   = freed_pg_ff;
            rsp_in.freed_count  = freed_cnt_ff;
            state_in       = S_IDLE;
         end
         S_HITWR: begin
            upd = wrk_ff;
            if (wrk_ff.refs != REFS_MAX) begin
               upd.refs = wrk_ff.refs + REFS_W'(1);
            end
            ent_we       = 1'b1;
            ent_wa       = best_idx_ff;
            ent_wd       = upd;
            rsp_valid_in = 1'b1;
            rsp_in       = '0;
            rsp_in.status       = STS_HIT;
            rsp_in.result_entry = best_idx_ff;
            rsp_in.first_page   = upd.page;
            rsp_in.page_count   = upd.span;
            rsp_in.ref_count    = upd.refs;
            state_in     = S_IDLE;
         end
         S_UREAD: begin
            rsp_in = '0;
            rsp_in.result_entry = id_ff;
            if (vld_ff[id_ff] && ent_q.refs != '0) begin
               upd.refs = ent_q.refs - REFS_W'(1);
               ent_we   = 1'b1;
               ent_wa   = id_ff;
               ent_wd   = upd;
               wrk_in   = upd;
               rsp_in.status     = STS_DROP;
               rsp_in.first_page = upd.page;
               rsp_in.page_count = upd.span;
               rsp_in.ref_count  = upd.refs;
               if (upd.refs == '0 && lazy_ff) begin
                  state_in = S_ADD1;
               end else begin
                  if (upd.refs == '0) begin
                     vld_in[id_ff] = 1'b0;
                     rsp_in.freed_valid = 1'b1;
                     rsp_in.freed_page  = upd.page;
                     rsp_in.freed_count = upd.span;
                     if (dep_ff != CNT_W'(ENTRIES)) begin
                        stk_we = 1'b1;
                        stk_wr_in[dep_ff[IDX_W-1:0]] = 1'b1;
                        dep_in = dep_ff + CNT_W'(1);
                     end
                  end
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end else begin
               rsp_in.status = STS_IDLE;
               if (vld_ff[id_ff]) begin
                  rsp_in.first_page = ent_q.page;
                  rsp_in.page_count = ent_q.span;
                  rsp_in.ref_count  = ent_q.refs;
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_ADD1: begin
            nxt_we   = 1'b1;
            nxt_wa   = id_ff;
            nxt_wd   = head_ff;
            prv_we   = 1'b1;
            prv_wa   = id_ff;
            prv_wd   = LNK_NULL;
            state_in = S_ADD2;
         end
         S_ADD2: begin
            if (head_ff != LNK_NULL) begin
               prv_we = 1'b1;
               prv_wa = head_ff[IDX_W-1:0];
               prv_wd = {1'b0, id_ff};
            end
            head_in = {1'b0, id_ff};
            if (tail_ff == LNK_NULL) begin
               tail_in = {1'b0, id_ff};
            end
            rsp_valid_in = 1'b1;
            rsp_in = '0;
            rsp_in.status       = STS_DROP;
            rsp_in.result_entry = id_ff;
            rsp_in.first_page   = wrk_ff.page;
            rsp_in.page_count   = wrk_ff.span;
            rsp_in.ref_count    = wrk_ff.refs;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vld_ff       <= '0;
         stk_wr_ff    <= '0;
         dep_ff       <= CNT_W'(ENTRIES);
         ctr_ff       <= '0;
         head_ff      <= LNK_NULL;
         tail_ff      <= LNK_NULL;
         lazy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vld_ff       <= vld_in;
         stk_wr_ff    <= stk_wr_in;
         dep_ff       <= dep_in;
         ctr_ff       <= ctr_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         lazy_ff      <= lazy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff       <= cnt_in;
      first_ff     <= first_in;
      endpg_ff     <= endpg_in;
      npg_ff       <= npg_in;
      best_vld_ff  <= best_vld_in;
      best_idx_ff  <= best_idx_in;
      best_age_ff  <= best_age_in;
      wrk_ff       <= wrk_in;
      tgt_ff       <= tgt_in;
      evict_ff     <= evict_in;
      freed_vld_ff <= freed_vld_in;
      freed_pg_ff  <= freed_pg_in;
      freed_cnt_ff <= freed_cnt_in;
      id_ff        <= id_in;
      rsp_ff       <= rsp_in;
   end

   a_depth_range: assert property (@(posedge clock) disable iff (reset)
      dep_ff <= CNT_W'(ENTRIES))
      else $error("free stack depth out of range");

   a_list_ends: assert property (@(posedge clock) disable iff (reset)
      (head_ff == LNK_NULL) == (tail_ff == LNK_NULL))
      else $error("idle list head and tail disagree on emptiness");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result beat without work in progress");

   a_none_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STS_NONE) |->
         (rsp_data.result_entry == '0 && !rsp_data.freed_valid))
      else $error("no-entry result carries data");

endmodule

@@ src/mrc_ram.sv @@
module mrc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import mrc_pkg::*;

   localparam int  NUL         = ENTRIES;
   localparam longint MAX_CYCLES = 3000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   mrc_req_type req_data = '0;
   logic        rsp_valid;
   mrc_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_data = 1'b0;

   memory_registration_cache_unit u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   // Shadow copy of the cache state.
   logic              lazy_mode;
   logic              ent_valid [ENTRIES];
   logic [PN_W-1:0]   ent_page  [ENTRIES];
   logic [SPAN_W-1:0] ent_span  [ENTRIES];
   logic [REFS_W-1:0] ent_refs  [ENTRIES];
   logic [31:0]       ent_stamp [ENTRIES];
   logic [31:0]       insert_ctr;
   int                free_stk  [ENTRIES];
   int                free_cnt;
   int                lru_next  [ENTRIES];
   int                lru_prev  [ENTRIES];
   int                lru_head, lru_tail;

   mrc_req_type request_q [$];
   mrc_rsp_type expected_rsp_q [$];
   int  sender_idle_pct = 0;
   int  mismatches = 0, beats_sent = 0, beats_seen = 0;
   int  status_seen [5] = '{0, 0, 0, 0, 0};
   longint cycles = 0;

   task automatic cache_reset();
      lazy_mode = 1'b1;
      insert_ctr = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         ent_valid[i] = 1'b0;
         free_stk[i] = ENTRIES - 1 - i;
         lru_next[i] = NUL;
         lru_prev[i] = NUL;
      end
      free_cnt = ENTRIES;
      lru_head = NUL;
      lru_tail = NUL;
   endtask

   task automatic lru_unlink(int d);
      int p, n;
      p = lru_prev[d];
      n = lru_next[d];
      lru_next[d] = NUL;
      lru_prev[d] = NUL;
      if (p < ENTRIES) lru_next[p] = n;
      if (n < ENTRIES) lru_prev[n] = p;
      if (lru_head == d) lru_head = n;
      if (lru_tail == d) lru_tail = p;
   endtask

   task automatic lru_push_head(int d);
      lru_next[d] = lru_head;
      lru_prev[d] = NUL;
      if (lru_head < ENTRIES) lru_prev[lru_head] = d;
      lru_head = d;
      if (lru_tail >= ENTRIES) lru_tail = d;
   endtask

   task automatic free_push(int d);
      if (free_cnt < ENTRIES) begin
         free_stk[free_cnt] = d;
         free_cnt++;
      end
   endtask

   task automatic cache_predict(input mrc_req_type r, output mrc_rsp_type o);
      logic [63:0] len, last, npages;
      logic [PN_W-1:0] first;
      logic [31:0] age, best_age;
      int best, d, v;
      o = '0;
      if (r.func == FUNC_REG) begin
         len = (r.length == 0) ? 64'd1 : 64'(r.length);
         last = 64'(r.address) + len - 1;
         first = PN_W'(r.address >> PAGE_BITS);
         npages = (last >> PAGE_BITS) - (64'(r.address) >> PAGE_BITS) + 1;
         best = NUL;
         best_age = '0;
         for (int i = 0; i < ENTRIES; i++) begin
            if (ent_valid[i] && ent_page[i] == first && 64'(ent_span[i]) >= npages) begin
               age = insert_ctr - ent_stamp[i];
               if (best >= ENTRIES || age < best_age) begin
                  best = i;
                  best_age = age;
               end
            end
         end
         if (best < ENTRIES) begin
            d = best;
            if (ent_refs[d] == 0) lru_unlink(d);
            if (ent_refs[d] != REFS_MAX) ent_refs[d]++;
            o.status = STS_HIT;
         end else begin
            if (free_cnt == 0) begin
               v = lru_tail;
               if (v >= ENTRIES) begin
                  o.status = STS_NONE;
                  return;
               end
               lru_unlink(v);
               ent_valid[v] = 1'b0;
               o.freed_valid = 1'b1;
               o.freed_page = ent_page[v];
               o.freed_count = ent_span[v];
               free_push(v);
            end
            free_cnt--;
            d = free_stk[free_cnt];
            ent_valid[d] = 1'b1;
            ent_page[d] = first;
            ent_span[d] = (npages > 64'(SPAN_MAX)) ? SPAN_MAX : SPAN_W'(npages);
            ent_refs[d] = REFS_W'(1);
            ent_stamp[d] = insert_ctr;
            insert_ctr++;
            lru_next[d] = NUL;
            lru_prev[d] = NUL;
            o.status = STS_NEW;
         end
      end else begin
         d = r.entry_id;
         if (ent_valid[d] && ent_refs[d] > 0) begin
            ent_refs[d]--;
            if (ent_refs[d] == 0) begin
               if (lazy_mode) begin
                  lru_push_head(d);
               end else begin
                  ent_valid[d] = 1'b0;
                  o.freed_valid = 1'b1;
                  o.freed_page = ent_page[d];
                  o.freed_count = ent_span[d];
                  free_push(d);
               end
            end
            o.status = STS_DROP;
         end else begin
            o.status = STS_IDLE;
            o.result_entry = r.entry_id;
            if (!ent_valid[d]) return;
         end
      end
      o.result_entry = 6'(d);
      o.first_page = ent_page[d];
      o.page_count = ent_span[d];
      o.ref_count = ent_refs[d];
   endtask

   // Request driver: one beat is taken at each edge where start is high and busy is low.
   always @(posedge clock) begin
      mrc_rsp_type exp_rsp;
      cycles++;
      if (cycles > MAX_CYCLES) begin
         $display("Timeout after %0d cycles.", cycles);
         $display("FAIL");
         $finish;
      end else if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            cache_predict(req_data, exp_rsp);
            expected_rsp_q.push_back(exp_rsp);
            beats_sent++;
         end
         if (!start || !busy) begin
            if (request_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               start <= 1'b1;
               req_data <= request_q.pop_front();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      mrc_rsp_type exp_rsp;
      if (!reset && rsp_valid) begin
         beats_seen++;
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: unexpected response, actual %p", $realtime, rsp_data);
            mismatches++;
         end else begin
            exp_rsp = expected_rsp_q.pop_front();
            if (rsp_data.status < 5) status_seen[rsp_data.status]++;
            if (rsp_data !== exp_rsp) begin
               $display("%0t: response mismatch, expected %p actual %p",
                        $realtime, exp_rsp, rsp_data);
               mismatches++;
            end
         end
      end
   end

   function automatic mrc_req_type make_reg(logic [47:0] addr, logic [30:0] len);
      mrc_req_type r;
      r.func = FUNC_REG;
      r.address = addr;
      r.length = len;
      r.entry_id = 6'($urandom);
      return r;
   endfunction

   function automatic mrc_req_type make_unreg(logic [5:0] id);
      mrc_req_type r;
      r.func = ~FUNC_REG;
      r.address = 48'({$urandom, $urandom});
      r.length = 31'($urandom);
      r.entry_id = id;
      return r;
   endfunction

   function automatic mrc_req_type random_item(int burst);
      logic [47:0] addr;
      logic [30:0] len;
      int pick;
      pick = $urandom_range(99);
      if (burst > 0) begin
         addr = {12'($urandom), 24'(burst), 12'($urandom)};
         return make_reg(addr, 31'($urandom_range(1, 30000)));
      end
      if (pick < 50) begin
         addr = {36'($urandom_range(0, 11)) + 36'h123456, 12'($urandom)};
         len = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 20000));
         return make_reg(addr, len);
      end else if (pick < 55) begin
         return make_reg(48'({$urandom, $urandom}), 31'($urandom));
      end else if (pick < 90) begin
         return make_unreg(6'($urandom_range(0, 15)));
      end
      return make_unreg(6'($urandom));
   endfunction

   task automatic csr_write(logic value);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      lazy_mode = value;
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (request_q.size() > 0 || start || expected_rsp_q.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      cache_reset();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_write(1'b1);

      // Extremes of each field, zero and maximal lengths, bad unregisters.
      request_q.push_back(make_reg(48'h0, 31'd0));
      request_q.push_back(make_reg(48'h0, 31'd1));
      request_q.push_back(make_reg(48'h0, 31'd4096));
      request_q.push_back(make_reg(48'h0, 31'd4097));
      request_q.push_back(make_reg(48'hFFFF_FFFF_FFFF, 31'h7FFF_FFFF));
      request_q.push_back(make_reg(48'hFFFF_FFFF_FFFF, 31'd1));
      request_q.push_back(make_reg(48'h0000_0000_0FFF, 31'h7FFF_FFFF));
      request_q.push_back(make_reg(48'hAAAA_AAAA_AAAA, 31'h5555_5555));
      request_q.push_back(make_reg(48'h5555_5555_5555, 31'h2AAA_AAAA));
      request_q.push_back(make_reg(48'h0, 31'd100));
      request_q.push_back(make_unreg(6'd0));
      request_q.push_back(make_unreg(6'd0));
      request_q.push_back(make_unreg(6'd0));
      request_q.push_back(make_unreg(6'd0));
      request_q.push_back(make_unreg(6'd63));
      request_q.push_back(make_unreg(6'd1));
      request_q.push_back(make_unreg(6'd1));
      request_q.push_back(make_reg(48'hFFFF_FFFF_F000, 31'd4096));
      request_q.push_back(make_unreg(6'd2));
      request_q.push_back(make_reg(48'h0, 31'd5000));
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 61 : 0;
         csr_write(phase != 1);
         // A run of distinct pages exhausts the free stack, then mixed traffic.
         for (int i = 0; i < 70; i++) request_q.push_back(random_item(i + 1));
         for (int i = 0; i < 160; i++) request_q.push_back(random_item(0));
         drain();
      end

      repeat (20) @(posedge clock);
      $display("Ran %0d beats, %0d responses: hit %0d, new %0d, none %0d, drop %0d, idle %0d.",
               beats_sent, beats_seen, status_seen[0], status_seen[1], status_seen[2],
               status_seen[3], status_seen[4]);
      $display("Both lazy and eager release modes were covered with eviction.");
      if (mismatches == 0 && expected_rsp_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
